// File: rtl/cvts_pkg.sv
// Package for the copy vector thread split block: payload types, widths and
// configuration register indexes. No dependencies.
package cvts_pkg;

  localparam int MAX_VECTOR_BITS_DEF = 128;
  localparam int DIV_W = 48;
  localparam int GCD_W = 16;
  localparam int THR_W = 11;
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 11;

  localparam logic [CFG_AW-1:0] CFG_TOTAL_THREADS = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_FAVOR_PRED = 1'd1;

  typedef struct packed {
    logic [15:0] alignment;
    logic [7:0]  element_bits;
    logic [1:0]  num_dims;
    logic [15:0] size_inner;
    logic [15:0] size_middle;
    logic [15:0] size_outer;
  } in_t;

  typedef struct packed {
    logic [7:0]       vector_size;
    logic [THR_W-1:0] threads_inner;
    logic [THR_W-1:0] threads_middle;
    logic [THR_W-1:0] threads_outer;
    logic [15:0]      tile_inner;
    logic [15:0]      tile_middle;
    logic [15:0]      tile_outer;
    logic             predicated;
    logic             width_error;
  } out_t;

endpackage

// File: rtl/cvts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module cvts_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  d_r;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {r_r, q_r[W-1]};
  assign fits = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (cnt_r != '0) begin
      if (fits) begin
        r_r <= W'(shifted - {1'b0, d_r});
      end else begin
        r_r <= shifted[W-1:0];
      end
      q_r <= {q_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

// File: rtl/copy_vector_thread_split.sv
// Copy vector thread split: one request in, one result out, all divisions on one shared iterative
// divider. A request needs up to one lane division, two gcd chains, up to log2(lanes)+1 halving
// tests and, per dimension, a gcd chain, a thread and a tile division, with a scale division for
// the inner dimension only. The block takes no new request until the previous result has gone to
// the output register. Synchronous active-low reset clears the sequencer and the result valid.
module copy_vector_thread_split #(
  parameter int MAX_VECTOR_BITS = cvts_pkg::MAX_VECTOR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cvts_pkg::in_t           in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cvts_pkg::out_t          out_data,
  input  logic                    cfg_we,
  input  logic [cvts_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cvts_pkg::CFG_DW-1:0] cfg_wdata
);
  import cvts_pkg::*;

  localparam int VW = $clog2(MAX_VECTOR_BITS + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LANES   = 5'd1;
  localparam logic [4:0] S_LANES_W = 5'd2;
  localparam logic [4:0] S_GCD     = 5'd3;
  localparam logic [4:0] S_GCD_W   = 5'd4;
  localparam logic [4:0] S_G1_DONE = 5'd5;
  localparam logic [4:0] S_G2_DONE = 5'd6;
  localparam logic [4:0] S_MUL2    = 5'd7;
  localparam logic [4:0] S_PRED    = 5'd8;
  localparam logic [4:0] S_PRED_DV = 5'd9;
  localparam logic [4:0] S_PRED_W  = 5'd10;
  localparam logic [4:0] S_SPLIT   = 5'd11;
  localparam logic [4:0] S_DIM     = 5'd12;
  localparam logic [4:0] S_SCALE_W = 5'd13;
  localparam logic [4:0] S_DIM_G   = 5'd14;
  localparam logic [4:0] S_REM_W   = 5'd15;
  localparam logic [4:0] S_TILE    = 5'd16;
  localparam logic [4:0] S_TILE_W  = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  logic [THR_W-1:0]    cfg_threads_r;
  logic                cfg_favor_r;
  logic [4:0]          state_r;
  logic [4:0]          ret_r;
  in_t                 in_r;
  logic [1:0]          nd_r;
  logic [THR_W-1:0]    threads_r;
  logic                pred_r;
  logic                werr_r;
  logic [VW-1:0]       lanes_r;
  logic [VW-1:0]       maxvec_r;
  logic [VW-1:0]       vec_r;
  logic [GCD_W-1:0]    a_r;
  logic [GCD_W-1:0]    b_r;
  logic [31:0]         cnt32_r;
  logic [DIV_W-1:0]    count_r;
  logic [THR_W+VW-1:0] prod_r;
  logic [1:0]          d_r;
  logic [THR_W-1:0]    rem_thr_r;
  logic [THR_W-1:0]    g_r;
  logic [THR_W-1:0]    thr_r [3];
  logic [15:0]         tile_r [3];
  logic                out_valid_r;
  out_t                out_r;

  logic                div_start;
  logic [DIV_W-1:0]    div_a;
  logic [DIV_W-1:0]    div_b;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;
  logic [DIV_W-1:0]    div_rem;
  logic                ebits_ok;
  logic [15:0]         dim_sel;

  assign ebits_ok = (in_r.element_bits != 8'd0) &&
                    (32'(in_r.element_bits) <= MAX_VECTOR_BITS);
  assign dim_sel = (d_r == 2'd0) ? in_r.size_inner :
                   (d_r == 2'd1) ? in_r.size_middle : in_r.size_outer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_threads_r <= THR_W'(32);
      cfg_favor_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TOTAL_THREADS: cfg_threads_r <= cfg_wdata;
        CFG_FAVOR_PRED:    cfg_favor_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_r)
      S_LANES: begin
        div_start = ebits_ok;
        div_a     = DIV_W'(MAX_VECTOR_BITS);
        div_b     = DIV_W'(in_r.element_bits);
      end
      S_GCD: begin
        div_start = (b_r != '0);
        div_a     = DIV_W'(a_r);
        div_b     = DIV_W'(b_r);
      end
      S_PRED_DV: begin
        div_start = 1'b1;
        div_a     = count_r;
        div_b     = DIV_W'(prod_r);
      end
      S_DIM: begin
        div_start = (d_r == 2'd0);
        div_a     = DIV_W'(in_r.size_inner);
        div_b     = DIV_W'(vec_r);
      end
      S_DIM_G: begin
        div_start = 1'b1;
        div_a     = DIV_W'(rem_thr_r);
        div_b     = DIV_W'(a_r);
      end
      S_TILE: begin
        div_start = 1'b1;
        div_a     = DIV_W'(17'(dim_sel) + 17'(g_r) - 17'd1);
        div_b     = DIV_W'(g_r);
      end
      default: ;
    endcase
  end

  cvts_div #(
    .W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r      <= in_data;
            nd_r      <= (in_data.num_dims == 2'd0) ? 2'd1 : in_data.num_dims;
            threads_r <= (cfg_threads_r == '0) ? THR_W'(1) : cfg_threads_r;
            pred_r    <= cfg_favor_r;
            for (int i = 0; i < 3; i++) begin
              thr_r[i]  <= '0;
              tile_r[i] <= '0;
            end
            state_r <= S_LANES;
          end
        end
        S_LANES: begin
          a_r   <= in_r.alignment;
          b_r   <= in_r.size_inner;
          ret_r <= S_G1_DONE;
          if (ebits_ok) begin
            state_r <= S_LANES_W;
          end else begin
            lanes_r <= VW'(1);
            werr_r  <= 1'b1;
            state_r <= S_GCD;
          end
        end
        S_LANES_W: begin
          if (div_done) begin
            lanes_r <= div_quo[VW-1:0];
            werr_r  <= (div_rem != '0);
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          state_r <= (b_r == '0) ? ret_r : S_GCD_W;
        end
        S_GCD_W: begin
          if (div_done) begin
            a_r     <= b_r;
            b_r     <= div_rem[GCD_W-1:0];
            state_r <= S_GCD;
          end
        end
        S_G1_DONE: begin
          b_r     <= GCD_W'(lanes_r);
          ret_r   <= S_G2_DONE;
          state_r <= S_GCD;
        end
        S_G2_DONE: begin
          maxvec_r <= (a_r == '0) ? VW'(1) : a_r[VW-1:0];
          vec_r    <= (a_r == '0) ? VW'(1) : a_r[VW-1:0];
          cnt32_r  <= 32'(in_r.size_inner) *
                      32'((nd_r != 2'd1) ? in_r.size_middle : 16'd1);
          state_r  <= S_MUL2;
        end
        S_MUL2: begin
          count_r <= DIV_W'(cnt32_r) *
                     DIV_W'((nd_r == 2'd3) ? in_r.size_outer : 16'd1);
          state_r <= S_PRED;
        end
        S_PRED: begin
          if (pred_r) begin
            state_r <= S_SPLIT;
          end else if (vec_r == '0) begin
            vec_r   <= maxvec_r;
            pred_r  <= 1'b1;
            state_r <= S_SPLIT;
          end else begin
            prod_r  <= (THR_W+VW)'(threads_r) * (THR_W+VW)'(vec_r);
            state_r <= S_PRED_DV;
          end
        end
        S_PRED_DV: begin
          state_r <= S_PRED_W;
        end
        S_PRED_W: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state_r <= S_SPLIT;
            end else begin
              vec_r   <= vec_r >> 1;
              state_r <= S_PRED;
            end
          end
        end
        S_SPLIT: begin
          d_r       <= 2'd0;
          rem_thr_r <= threads_r;
          state_r   <= S_DIM;
        end
        S_DIM: begin
          if (d_r == 2'd0) begin
            state_r <= S_SCALE_W;
          end else begin
            a_r     <= GCD_W'(rem_thr_r);
            b_r     <= dim_sel;
            ret_r   <= S_DIM_G;
            state_r <= S_GCD;
          end
        end
        S_SCALE_W: begin
          if (div_done) begin
            a_r     <= GCD_W'(rem_thr_r);
            b_r     <= div_quo[GCD_W-1:0];
            ret_r   <= S_DIM_G;
            state_r <= S_GCD;
          end
        end
        S_DIM_G: begin
          g_r        <= a_r[THR_W-1:0];
          thr_r[d_r] <= a_r[THR_W-1:0];
          state_r    <= S_REM_W;
        end
        S_REM_W: begin
          if (div_done) begin
            rem_thr_r <= div_quo[THR_W-1:0];
            state_r   <= S_TILE;
          end
        end
        S_TILE: begin
          state_r <= S_TILE_W;
        end
        S_TILE_W: begin
          if (div_done) begin
            tile_r[d_r] <= div_quo[15:0];
            if (d_r == nd_r - 2'd1) begin
              state_r <= S_DONE;
            end else begin
              d_r     <= d_r + 2'd1;
              state_r <= S_DIM;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_r.vector_size    <= 8'(vec_r);
      out_r.threads_inner  <= thr_r[0];
      out_r.threads_middle <= thr_r[1];
      out_r.threads_outer  <= thr_r[2];
      out_r.tile_inner     <= tile_r[0];
      out_r.tile_middle    <= tile_r[1];
      out_r.tile_outer     <= tile_r[2];
      out_r.predicated     <= pred_r;
      out_r.width_error    <= werr_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LANES)
    else $error("accepted transfer did not start the sequence");

  a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_LANES_W || state_r == S_GCD_W ||
                  state_r == S_PRED_W || state_r == S_SCALE_W ||
                  state_r == S_REM_W || state_r == S_TILE_W))
    else $error("divider finished while the sequencer was not waiting");

  a_vec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIM |-> vec_r != '0)
    else $error("vector size is zero during the thread split");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIM_G |-> a_r != '0)
    else $error("thread count of a dimension is zero");

endmodule

// File: tb/sv/tb.sv
// Testbench for copy_vector_thread_split: directed table plus random requests
// under several thread settings and handshake idling patterns, checked by a predictor.
// Depends on rtl/cvts_pkg.sv and rtl/copy_vector_thread_split.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvts_pkg::*;

  localparam int LANE_BITS = 128;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t split;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  out_t split_q[$];
  logic [10:0] cur_threads;
  logic cur_favor;
  int send_idle_pct, recv_stall_pct, hold_cycles, idle_count, errors, results_seen;

  copy_vector_thread_split dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic out_t predict_split(in_t r);
    out_t o;
    longint unsigned thr, nd, lanes, maxv, vec, cnt, left, s, g;
    longint unsigned dims[3], tcnt[3], tl[3];
    bit pred;
    thr = (cur_threads == 0) ? 1 : cur_threads;
    nd = (r.num_dims == 0) ? 1 : r.num_dims;
    dims[0] = r.size_inner;
    dims[1] = r.size_middle;
    dims[2] = r.size_outer;
    tcnt = '{0, 0, 0};
    tl = '{0, 0, 0};
    pred = cur_favor;
    o.width_error = (r.element_bits == 0) || (LANE_BITS % r.element_bits != 0);
    lanes = (r.element_bits == 0 || r.element_bits > LANE_BITS) ? 1 :
            LANE_BITS / r.element_bits;
    maxv = gcd64(gcd64(r.alignment, dims[0]), lanes);
    if (maxv == 0) maxv = 1;
    cnt = 1;
    for (int d = 0; d < nd; d++) cnt *= dims[d];
    vec = maxv;
    if (!pred) begin
      while (vec >= 1 && cnt % (thr * vec) != 0) vec /= 2;
      if (vec == 0) begin
        vec = maxv;
        pred = 1;
      end
    end
    left = thr;
    for (int d = 0; d < nd; d++) begin
      s = (d == 0) ? dims[0] / vec : dims[d];
      g = gcd64(left, s);
      tcnt[d] = g;
      left /= g;
      tl[d] = (dims[d] + g - 1) / g;
    end
    o.vector_size = vec[7:0];
    o.threads_inner = tcnt[0][10:0];
    o.threads_middle = tcnt[1][10:0];
    o.threads_outer = tcnt[2][10:0];
    o.tile_inner = tl[0][15:0];
    o.tile_middle = tl[1][15:0];
    o.tile_outer = tl[2][15:0];
    o.predicated = pred;
    return o;
  endfunction

  function automatic logic [15:0] rand_extent();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 16'd0;
    if (r < 15) return 16'($urandom_range(1, 16) << $urandom_range(0, 11));
    return 16'($urandom);
  endfunction

  function automatic in_t rand_request();
    in_t r;
    r.alignment = rand_extent();
    r.element_bits = ($urandom_range(9) < 8) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
    r.num_dims = 2'($urandom);
    r.size_inner = rand_extent();
    r.size_middle = rand_extent();
    r.size_outer = rand_extent();
    return r;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_TOTAL_THREADS) cur_threads = val;
    else cur_favor = val[0];
    @(posedge clk);
  endtask

  task automatic send_request(in_t r, bit typed, out_t split);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    split_q.insert(split_q.size(), typed ? split : predict_split(r));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (split_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_phase(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) send_request(rand_request(), 1'b0, '0);
    drain();
  endtask

  task automatic check_field(string name, logic [15:0] e, logic [15:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, e, g);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_t e;
      if (split_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
      end else begin
        e = split_q.pop_front();
        results_seen++;
        check_field("vector_size", 16'(e.vector_size), 16'(out_data.vector_size));
        check_field("threads_inner", 16'(e.threads_inner), 16'(out_data.threads_inner));
        check_field("threads_middle", 16'(e.threads_middle), 16'(out_data.threads_middle));
        check_field("threads_outer", 16'(e.threads_outer), 16'(out_data.threads_outer));
        check_field("tile_inner", e.tile_inner, out_data.tile_inner);
        check_field("tile_middle", e.tile_middle, out_data.tile_middle);
        check_field("tile_outer", e.tile_outer, out_data.tile_outer);
        check_field("predicated", 16'(e.predicated), 16'(out_data.predicated));
        check_field("width_error", 16'(e.width_error), 16'(out_data.width_error));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t table_rows[] = '{
    '{'{16'd1, 8'd8, 2'd1, 16'd32, 16'd0, 16'd0}, 1,
      '{8'd1, 11'd32, 11'd0, 11'd0, 16'd1, 16'd0, 16'd0, 1'b0, 1'b0}},
    '{'{16'd1, 8'd0, 2'd1, 16'd32, 16'd0, 16'd0}, 1,
      '{8'd1, 11'd32, 11'd0, 11'd0, 16'd1, 16'd0, 16'd0, 1'b0, 1'b1}},
    '{'{16'd1, 8'd3, 2'd1, 16'd32, 16'd0, 16'd0}, 1,
      '{8'd1, 11'd32, 11'd0, 11'd0, 16'd1, 16'd0, 16'd0, 1'b0, 1'b1}},
    '{'{16'hFFFF, 8'd1, 2'd1, 16'hFFFF, 16'd0, 16'd0}, 1,
      '{8'd1, 11'd1, 11'd0, 11'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b0}},
    '{'{16'd128, 8'd1, 2'd3, 16'd4096, 16'd64, 16'd8}, 0, '0},
    '{'{16'd64, 8'd128, 2'd2, 16'd256, 16'd32, 16'd0}, 0, '0},
    '{'{16'd16, 8'd8, 2'd0, 16'd512, 16'd7, 16'd9}, 0, '0},
    '{'{16'd0, 8'd16, 2'd1, 16'd64, 16'd0, 16'd0}, 0, '0},
    '{'{16'd32, 8'd4, 2'd2, 16'd0, 16'd5, 16'd0}, 0, '0},
    '{'{16'd8, 8'd255, 2'd3, 16'd24, 16'd3, 16'd5}, 0, '0},
    '{'{16'd6, 8'd200, 2'd1, 16'd12, 16'd0, 16'd0}, 0, '0},
    '{'{16'd4, 8'd32, 2'd3, 16'd6, 16'hFFFF, 16'hFFFF}, 0, '0},
    '{'{16'd2, 8'd64, 2'd2, 16'd1, 16'd1, 16'd1}, 0, '0},
    '{'{16'd48, 8'd2, 2'd3, 16'd96, 16'd3, 16'd1}, 0, '0}
  };

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cur_threads = 11'd32;
    cur_favor = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    idle_count = 0;
    errors = 0;
    results_seen = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].typed,
                                         table_rows[i].split);
    drain();
    random_phase(80, 0, 0);
    write_reg(CFG_TOTAL_THREADS, CFG_DW'(1));
    write_reg(CFG_FAVOR_PRED, CFG_DW'(0));
    random_phase(80, 60, 0);
    write_reg(CFG_TOTAL_THREADS, CFG_DW'(1024));
    write_reg(CFG_FAVOR_PRED, CFG_DW'(1));
    random_phase(80, 0, 60);
    write_reg(CFG_TOTAL_THREADS, CFG_DW'(0));
    write_reg(CFG_FAVOR_PRED, CFG_DW'(0));
    random_phase(80, 38, 38);
    write_reg(CFG_TOTAL_THREADS, CFG_DW'($urandom_range(2, 1024)));
    write_reg(CFG_FAVOR_PRED, CFG_DW'($urandom_range(1)));
    hold_cycles = 8000;
    random_phase(70, 0, 0);
    write_reg(CFG_TOTAL_THREADS, CFG_DW'(2047));
    random_phase(46, 0, 0);
    $display("Covered %0d results over six thread settings, both search modes,", results_seen);
    $display("handshake idling on each side and one long receiver hold-off.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: copy_vector_thread_split.f
rtl/cvts_pkg.sv
rtl/cvts_div.sv
rtl/copy_vector_thread_split.sv
tb/sv/tb.sv
